>>> design/ubd_pkg.sv
`default_nettype none

package ubd_pkg;

    localparam int CLK_W  = 27;
    localparam int BAUD_W = 20;
    localparam int NUM_W  = CLK_W + 4;
    localparam int DIVR_W = BAUD_W + 1;
    localparam int QUO_W  = 24;
    localparam int INT_W  = 16;
    localparam int FRAC_W = 6;

    localparam logic [CLK_W-1:0]  CLK_RESET  = 27'd24000000;
    localparam logic [7:0]        DATA_MIN   = 8'd5;
    localparam logic [7:0]        DATA_MAX   = 8'd8;
    localparam logic [7:0]        STOP_MAX   = 8'd2;
    localparam logic [BAUD_W-1:0] BAUD_MIN   = 20'd110;
    localparam logic [BAUD_W-1:0] BAUD_MAX   = 20'd460800;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_WORD = 2'd1,
        ST_BAD_STOP = 2'd2,
        ST_BAD_BAUD = 2'd3
    } ubd_status_t;

    typedef struct packed {
        ubd_status_t       status;
        logic [1:0]        wlc;
        logic              parity;
        logic              two_stop;
        logic [DIVR_W-1:0] divisor;
        logic [DIVR_W-1:0] rem;
        logic [QUO_W-1:0]  num;
        logic [QUO_W-1:0]  quo;
    } ubd_beat_t;

endpackage

`default_nettype wire

>>> design/ubd_front.sv
`default_nettype none

module ubd_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [ubd_pkg::CLK_W-1:0]  ref_clk,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [7:0]                 char_bits,
    input  wire logic [7:0]                 stop_count,
    input  wire logic                       parity_on,
    input  wire logic [ubd_pkg::BAUD_W-1:0] baud_rate,
    input  wire logic                       down_adv,
    output logic                            valid,
    output ubd_pkg::ubd_beat_t              beat
);
    import ubd_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    ubd_beat_t        beat_reg;
    ubd_beat_t        beat_next;
    logic [NUM_W-1:0] numer;
    ubd_status_t      st;

    // Checks run in a fixed order; the first failure wins.
    always_comb
    begin
        if (char_bits < DATA_MIN || char_bits > DATA_MAX)
            st = ST_BAD_WORD;
        else if (stop_count == 8'd0 || stop_count > STOP_MAX)
            st = ST_BAD_STOP;
        else if (baud_rate < BAUD_MIN || baud_rate > BAUD_MAX)
            st = ST_BAD_BAUD;
        else
            st = ST_OK;
    end

    // Dividend is 8*clk + baud, divisor is 2*baud.
    assign numer = {1'b0, ref_clk, 3'b000} + {{(NUM_W-BAUD_W){1'b0}}, baud_rate};

    always_comb
    begin
        beat_next.status   = st;
        beat_next.wlc      = 2'(char_bits - DATA_MIN);
        beat_next.parity   = parity_on;
        beat_next.two_stop = (stop_count == STOP_MAX);
        beat_next.divisor  = {baud_rate, 1'b0};
        beat_next.rem      = {{(DIVR_W-(NUM_W-QUO_W)){1'b0}}, numer[NUM_W-1:QUO_W]};
        beat_next.num      = numer[QUO_W-1:0];
        beat_next.quo      = '0;
    end

    assign in_ready   = !valid_reg || down_adv;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            beat_reg <= beat_next;
    end

    assign valid = valid_reg;
    assign beat  = beat_reg;

endmodule

`default_nettype wire

>>> design/ubd_div_cell.sv
`default_nettype none

module ubd_div_cell (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         up_valid,
    input  wire ubd_pkg::ubd_beat_t up_beat,
    output logic              up_adv,
    input  wire logic         down_adv,
    output logic              valid,
    output ubd_pkg::ubd_beat_t beat
);
    import ubd_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    ubd_beat_t         beat_reg;
    ubd_beat_t         beat_next;
    logic [DIVR_W:0]   trial;
    logic [DIVR_W+1:0] diff;
    logic              ge;

    // One restoring step: bring in the next dividend bit and try a subtract.
    assign trial = {up_beat.rem, up_beat.num[QUO_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, up_beat.divisor};
    assign ge    = !diff[DIVR_W+1];

    always_comb
    begin
        beat_next     = up_beat;
        beat_next.rem = ge ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
        beat_next.num = {up_beat.num[QUO_W-2:0], 1'b0};
        beat_next.quo = {up_beat.quo[QUO_W-2:0], ge};
    end

    assign up_adv     = !valid_reg || down_adv;
    assign valid_next = up_adv ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (up_adv && up_valid)
            beat_reg <= beat_next;
    end

    assign valid = valid_reg;
    assign beat  = beat_reg;

endmodule

`default_nettype wire

>>> design/uart_baud_divisor_and_line_format.sv
// An accepted beat loads into the check stage and then moves through the 24 divider
// cells in order; the last cell drives the outputs. One beat per cycle while out_ready
// is high; a full stage advances only when the stage after it moves on.
// A stalled output only holds the stages that are full behind it.
// Reset (rst_n, asynchronous, active low) empties every stage and sets the
// reference clock register to 24000000.
`default_nettype none

module uart_baud_divisor_and_line_format (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // APB-style configuration port
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // Request channel
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [7:0]   char_bits,
    input  wire logic [7:0]   stop_count,
    input  wire logic         parity_on,
    input  wire logic [19:0]  baud_rate,
    // Result channel
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [1:0]        status,
    output logic [15:0]       int_divisor,
    output logic [5:0]        frac_divisor,
    output logic [1:0]        word_length_code,
    output logic              parity_enable,
    output logic              even_parity_select,
    output logic              stick_parity_select,
    output logic              two_stop
);
    import ubd_pkg::*;

    // The reference clock register. Software must write it only while the block
    // is idle (the block does not enforce this); the check stage reads it directly.
    logic [CLK_W-1:0] ref_clk_reg;
    logic [CLK_W-1:0] ref_clk_next;
    logic             cfg_wr;
    logic             cfg_hit;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[2] == 1'b0);
    assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;

    assign ref_clk_next = cfg_wr ? pwdata[CLK_W-1:0] : ref_clk_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ref_clk_reg <= CLK_RESET;
        else
            ref_clk_reg <= ref_clk_next;
    end

    assign prdata = cfg_hit ? {{(32-CLK_W){1'b0}}, ref_clk_reg} : 32'd0;

    // The check stage validates the request and forms the dividend
    // 8*clk + baud and the divisor 2*baud. The divisor is
    // floor((8*clk + baud) / (2*baud)), which is clk/(16*baud) rounded half up
    // in sixty-fourths, so a rounding carry lands in the integer part.
    logic      front_valid;
    ubd_beat_t front_beat;
    logic      front_adv;

    ubd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .ref_clk    (ref_clk_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .char_bits  (char_bits),
        .stop_count (stop_count),
        .parity_on  (parity_on),
        .baud_rate  (baud_rate),
        .down_adv   (front_adv),
        .valid      (front_valid),
        .beat       (front_beat)
    );

    // The row of divider cells. Each cell produces one quotient bit, most
    // significant first, and hands its partial remainder to the next cell.
    // For a valid baud rate the quotient always fits in 24 bits. A cell
    // loads whenever it is empty or the cell after it moves on.
    logic      cell_valid [QUO_W+1];
    ubd_beat_t cell_beat  [QUO_W+1];
    logic      cell_adv   [QUO_W+1];

    assign cell_valid[0] = front_valid;
    assign cell_beat[0]  = front_beat;
    assign front_adv     = cell_adv[0];

    for (genvar i = 0; i < QUO_W; i++)
    begin : g_cell
        ubd_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (cell_valid[i]),
            .up_beat  (cell_beat[i]),
            .up_adv   (cell_adv[i]),
            .down_adv (cell_adv[i+1]),
            .valid    (cell_valid[i+1]),
            .beat     (cell_beat[i+1])
        );
    end

    // The last cell is the output register.
    ubd_beat_t last;
    logic      ok;

    assign last            = cell_beat[QUO_W];
    assign cell_adv[QUO_W] = out_ready;
    assign out_valid       = cell_valid[QUO_W];
    assign ok              = (last.status == ST_OK);

    // A rejected request reports only its status; every other field is zero.
    // The integer part keeps its low 16 bits, as a 16-bit register would.
    assign status              = last.status;
    assign int_divisor         = ok ? last.quo[FRAC_W+INT_W-1:FRAC_W] : '0;
    assign frac_divisor        = ok ? last.quo[FRAC_W-1:0] : '0;
    assign word_length_code    = ok ? last.wlc : 2'd0;
    assign parity_enable       = ok && last.parity;
    assign even_parity_select  = ok && last.parity;
    assign stick_parity_select = ok && last.parity;
    assign two_stop            = ok && last.two_stop;

`ifndef ASSERT_OFF
    // With the output stage empty, nothing can hold back a new request.
    a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("request refused while the output stage is empty");

    // An accepted request always lands in the check stage.
    a_front_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> front_valid)
        else $error("accepted request lost in the check stage");

    // A stalled check stage keeps its beat.
    a_front_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (front_valid && !front_adv) |=> (front_valid && $stable(front_beat)))
        else $error("stalled check stage changed its beat");
`endif

endmodule

`default_nettype wire
